>>> design/bsa_pkg.sv
// Shared types and constants for the bitmap slot allocator.
// Used by the row unit and the allocator top level; no dependencies.
`timescale 1ns / 1ps

package bsa_pkg;

   // Used-bit map is stored as rows of this many slot bits
   localparam int ROW_BITS = 8;
   localparam int BIT_W    = 3;
   // Byte offsets within the page
   localparam int OFFSET_W = 12;

   // Request operation codes
   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_FREE   = 2'd1;
   localparam logic [1:0] OP_VERIFY = 2'd2;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_CHECK,
      ST_REPLY
   } state_type;

   // Row unit results
   typedef struct packed {
      logic                found;
      logic [BIT_W-1:0]    first_free;
      logic [ROW_BITS-1:0] set_row;
      logic [ROW_BITS-1:0] clear_row;
      logic                bit_value;
   } row_result_type;

endpackage

>>> design/bsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> design/bsa_row_unit.sv
// Shared row unit: find-first-free, set, clear and test on one map row.
// Depends on bsa_pkg.
`timescale 1ns / 1ps

module bsa_row_unit
   import bsa_pkg::*;
#(
   parameter int SLOT_COUNT = 128,
   parameter int ROW_W      = 4
) (
   input  logic [ROW_BITS-1:0] row_data,
   input  logic [ROW_W-1:0]    row_index,
   input  logic [BIT_W-1:0]    bit_sel,
   output row_result_type      result
);

   localparam int NUM_W = ROW_W + BIT_W + 1;

   logic [ROW_BITS-1:0] live;
   logic [ROW_BITS-1:0] free_bits;
   logic [BIT_W-1:0]    first;

   // Slots past the end of the page never count as free
   always_comb begin
      for (int b = 0; b < ROW_BITS; b++) begin
         live[b] = NUM_W'({row_index, BIT_W'(b)}) < NUM_W'(SLOT_COUNT);
      end
      free_bits = ~row_data & live;
   end

   // Lowest free bit wins
   always_comb begin
      first = '0;
      for (int b = ROW_BITS - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            first = BIT_W'(b);
         end
      end
   end

   always_comb begin
      result.found      = |free_bits;
      result.first_free = first;
      result.set_row    = row_data | (ROW_BITS'(1) << first);
      result.clear_row  = row_data & ~(ROW_BITS'(1) << bit_sel);
      result.bit_value  = row_data[bit_sel];
   end

endmodule

>>> design/bitmap_slot_allocator_core.sv
// Bitmap slot allocator top level: request sequencer, map RAM and row unit.
// Depends on bsa_pkg, bsa_ram and bsa_row_unit.
`timescale 1ns / 1ps

// Tracks one page of SLOT_COUNT slots of SLOT_BYTES bytes in a used-bit map
// kept in a RAM of 8-bit rows; slot 0 is the header and stays used. After
// reset a clearing pass writes every row, one per cycle, before the first
// request is taken. One request is handled at a time. Free and verify read
// the slot's row, check it in the row unit and then reply; when the offset
// lies beyond the page, or for the unused op code, the check is skipped.
// Allocate scans the map one row per read/check pair through the shared
// row unit, stopping at the first row holding a free slot or after the
// last row.
// Results sit in an output register, so a stalled result does not block the
// next request transfer.
module bitmap_slot_allocator_core
   import bsa_pkg::*;
#(
   parameter int SLOT_COUNT = 128,
   parameter int SLOT_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] object_offset, [15:12] zero
   input  logic [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [11:0] slot_offset, [15:12] zero
   output logic        rsp_tuser    // [0] success
);

   localparam int ROWS      = (SLOT_COUNT + ROW_BITS - 1) / ROW_BITS;
   localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SLOT_W    = ROW_W + BIT_W;
   localparam int SB_LOG    = $clog2(SLOT_BYTES);
   localparam int DIV_SHIFT = OFFSET_W + SB_LOG;
   localparam int RECIP     = ((1 << DIV_SHIFT) + SLOT_BYTES - 1) / SLOT_BYTES;
   localparam int PROD_W    = DIV_SHIFT + OFFSET_W;
   localparam int GRANT_W   = SLOT_W + $clog2(SLOT_BYTES + 1) + OFFSET_W;

   state_type state_ff, state_in;

   logic [1:0]          op_ff;
   logic [OFFSET_W-1:0] slot_ff;
   logic [ROW_W-1:0]    scan_row_ff, scan_row_in;
   logic [ROW_W-1:0]    clr_row_ff, clr_row_in;
   logic                res_success_ff, res_success_in;
   logic [OFFSET_W-1:0] res_offset_ff, res_offset_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_success_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff;

   logic                req_fire;
   logic                rsp_load;
   logic [PROD_W-1:0]   div_prod;
   logic                in_range;
   logic [ROW_W-1:0]    slot_row;
   logic [BIT_W-1:0]    slot_bit;
   logic                last_row;
   logic [GRANT_W-1:0]  grant_prod;

   logic                ram_wr_en;
   logic [ROW_W-1:0]    ram_wr_addr;
   logic [ROW_BITS-1:0] ram_wr_data;
   logic                ram_rd_en;
   logic [ROW_W-1:0]    ram_rd_addr;
   logic [ROW_BITS-1:0] ram_rd_data;
   row_result_type      unit_res;

   // Handshakes
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_load   = (state_ff == ST_REPLY) && (!rsp_valid_ff || rsp_tready);

   // Slot index = offset / SLOT_BYTES by reciprocal multiply (exact for 12 bits)
   assign div_prod = PROD_W'(req_tdata[OFFSET_W-1:0]) * PROD_W'(RECIP);

   assign in_range = {1'b0, slot_ff} < (OFFSET_W + 1)'(SLOT_COUNT);
   assign slot_row = slot_ff[SLOT_W-1:BIT_W];
   assign slot_bit = slot_ff[BIT_W-1:0];
   assign last_row = (scan_row_ff == ROW_W'(ROWS - 1));

   // Byte offset of a granted slot
   assign grant_prod = GRANT_W'({scan_row_ff, unit_res.first_free}) * GRANT_W'(SLOT_BYTES);

   bsa_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (ROWS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bsa_row_unit #(
      .SLOT_COUNT (SLOT_COUNT),
      .ROW_W      (ROW_W)
   ) u_row_unit (
      .row_data  (ram_rd_data),
      .row_index ((op_ff == OP_ALLOC) ? scan_row_ff : slot_row),
      .bit_sel   (slot_bit),
      .result    (unit_res)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_row_ff == ROW_W'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (op_ff == OP_ALLOC ||
                ((op_ff == OP_FREE || op_ff == OP_VERIFY) && in_range)) begin
               state_in = ST_CHECK;
            end else begin
               state_in = ST_REPLY;
            end
         end
         ST_CHECK: begin
            if (op_ff == OP_ALLOC && !unit_res.found && !last_row) begin
               state_in = ST_LOOKUP;
            end else begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Sequencer outputs: RAM control, clear and scan rows, pending result
   always_comb begin
      ram_wr_en      = 1'b0;
      ram_wr_addr    = clr_row_ff;
      ram_wr_data    = '0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = (op_ff == OP_ALLOC) ? scan_row_ff : slot_row;
      scan_row_in    = scan_row_ff;
      clr_row_in     = clr_row_ff;
      res_success_in = res_success_ff;
      res_offset_in  = res_offset_ff;
      case (state_ff)
         ST_CLEAR: begin
            // Header slot starts out used
            ram_wr_en   = 1'b1;
            ram_wr_data = (clr_row_ff == '0) ? ROW_BITS'(1) : '0;
            clr_row_in  = clr_row_ff + ROW_W'(1);
         end
         ST_IDLE: begin
            scan_row_in = '0;
         end
         ST_LOOKUP: begin
            ram_rd_en      = 1'b1;
            res_offset_in  = '0;
            // Beyond the page: free still reports 1, verify and unused op 0
            res_success_in = (op_ff == OP_FREE);
         end
         ST_CHECK: begin
            case (op_ff)
               OP_ALLOC: begin
                  if (unit_res.found) begin
                     ram_wr_en      = 1'b1;
                     ram_wr_addr    = scan_row_ff;
                     ram_wr_data    = unit_res.set_row;
                     res_success_in = 1'b1;
                     res_offset_in  = grant_prod[OFFSET_W-1:0];
                  end else begin
                     scan_row_in    = scan_row_ff + ROW_W'(1);
                     res_success_in = 1'b0;
                  end
               end
               OP_FREE: begin
                  // Freeing the header slot is ignored
                  ram_wr_en      = (slot_ff != '0);
                  ram_wr_addr    = slot_row;
                  ram_wr_data    = unit_res.clear_row;
                  res_success_in = 1'b1;
               end
               OP_VERIFY: begin
                  res_success_in = unit_res.bit_value;
               end
               default: begin
                  res_success_in = 1'b0;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_row_ff   <= '0;
         scan_row_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         scan_row_ff  <= scan_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_tuser;
         slot_ff <= div_prod[PROD_W-1:DIV_SHIFT];
      end
      res_success_ff <= res_success_in;
      res_offset_ff  <= res_offset_in;
      if (rsp_load) begin
         rsp_success_ff <= res_success_ff;
         rsp_offset_ff  <= res_offset_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_success_ff;
   assign rsp_tdata  = {4'b0, rsp_offset_ff};

endmodule
